FILE: sv/tapm_pkg.sv
`timescale 1ns / 1ps

package tapm_pkg;

    localparam int NUM_CH       = 2;
    localparam int ANGLE_WINDOW = 25;
    localparam int PWM_WINDOW   = 16;

    localparam int ANGLE_W     = 16;
    localparam int PWM_W       = 20;
    localparam int SLOPE_W     = 24;
    localparam int OFFSET_W    = 32;
    localparam int SLOPE_SHIFT = 12;
    localparam int MAP_W       = OFFSET_W + 2;
    localparam int PROD_W      = SLOPE_W + ANGLE_W;

    localparam logic [PWM_W-1:0] PWM_MAX = '1;

    // angle window: running sum and exact divide by reciprocal multiply
    localparam int ANGLE_SLOT_W    = $clog2(ANGLE_WINDOW);
    localparam int ANGLE_SUM_W     = ANGLE_W + $clog2(ANGLE_WINDOW);
    localparam int ANGLE_DIV_SHIFT = ANGLE_SUM_W + 7;
    localparam int ANGLE_RECIP_W   = ANGLE_DIV_SHIFT - $clog2(ANGLE_WINDOW) + 1;
    localparam logic [ANGLE_RECIP_W-1:0] ANGLE_RECIP = ANGLE_RECIP_W'(
        ((64'd1 << ANGLE_DIV_SHIFT) + 64'(ANGLE_WINDOW) - 64'd1) / 64'(ANGLE_WINDOW));

    // pwm window: running sum, then (raw + sum) / (window + 1)
    localparam int PWM_DIV       = PWM_WINDOW + 1;
    localparam int PWM_SLOT_W    = $clog2(PWM_WINDOW);
    localparam int PWM_SUM_W     = PWM_W + $clog2(PWM_WINDOW);
    localparam int PWM_ACC_W     = PWM_W + $clog2(PWM_DIV);
    localparam int PWM_DIV_SHIFT = PWM_ACC_W + 7;
    localparam int PWM_RECIP_W   = PWM_DIV_SHIFT - $clog2(PWM_DIV) + 1;
    localparam logic [PWM_RECIP_W-1:0] PWM_RECIP = PWM_RECIP_W'(
        ((64'd1 << PWM_DIV_SHIFT) + 64'(PWM_DIV) - 64'd1) / 64'(PWM_DIV));

    // configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        CFG_MIN_A,
        CFG_MAX_A,
        CFG_SLOPE_A,
        CFG_OFFSET_A,
        CFG_MIN_B,
        CFG_MAX_B,
        CFG_SLOPE_B,
        CFG_OFFSET_B
    } cfg_idx_t;

    localparam logic signed [ANGLE_W-1:0]  MIN_ANGLE_A_RST = 16'sd2880;
    localparam logic signed [ANGLE_W-1:0]  MAX_ANGLE_A_RST = 16'sd5760;
    localparam logic signed [SLOPE_W-1:0]  SLOPE_A_RST     = -24'sd239217;
    localparam logic signed [OFFSET_W-1:0] OFFSET_A_RST    = 32'sd396500;
    localparam logic signed [ANGLE_W-1:0]  MIN_ANGLE_B_RST = 16'sd2880;
    localparam logic signed [ANGLE_W-1:0]  MAX_ANGLE_B_RST = 16'sd5760;
    localparam logic signed [SLOPE_W-1:0]  SLOPE_B_RST     = 24'sd239217;
    localparam logic signed [OFFSET_W-1:0] OFFSET_B_RST    = -32'sd108100;

endpackage

FILE: sv/tilt_angle_to_servo_pwm_mapper.sv
`timescale 1ns / 1ps

// throughput: one request per cycle; five register stages (angle window, /25 multiply,
//   slope multiply, saturate and pwm window, /17 multiply) all advance together and
//   hold while the output register is full and m_ready is low
// reset: synchronous, active low; clears both windows, running sums, slots and
//   pipeline valids, and loads the default bounds, slopes and offsets
module tilt_angle_to_servo_pwm_mapper (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [tapm_pkg::ANGLE_W-1:0]     s_angle_a,
    input  logic signed [tapm_pkg::ANGLE_W-1:0]     s_angle_b,
    input  logic        [tapm_pkg::PWM_W-1:0]       s_fallback_pwm_a,
    input  logic        [tapm_pkg::PWM_W-1:0]       s_fallback_pwm_b,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic        [tapm_pkg::PWM_W-1:0]       m_pwm_a,
    output logic        [tapm_pkg::PWM_W-1:0]       m_pwm_b,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic        [tapm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic        [tapm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic        [tapm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                    pready
);

    localparam int NCH = tapm_pkg::NUM_CH;

    // configuration
    logic signed [tapm_pkg::ANGLE_W-1:0]  min_angle_reg [NCH];
    logic signed [tapm_pkg::ANGLE_W-1:0]  max_angle_reg [NCH];
    logic signed [tapm_pkg::SLOPE_W-1:0]  slope_reg     [NCH];
    logic signed [tapm_pkg::OFFSET_W-1:0] offset_reg    [NCH];
    tapm_pkg::cfg_idx_t                   cfg_idx;

    // window state
    logic signed [tapm_pkg::ANGLE_W-1:0]     angle_hist_reg  [NCH][tapm_pkg::ANGLE_WINDOW];
    logic signed [tapm_pkg::ANGLE_SUM_W-1:0] angle_total_reg [NCH];
    logic signed [tapm_pkg::ANGLE_SUM_W-1:0] angle_total_next [NCH];
    logic        [tapm_pkg::ANGLE_SLOT_W-1:0] angle_slot_reg;
    logic        [tapm_pkg::ANGLE_SLOT_W-1:0] angle_slot_next;
    logic        [tapm_pkg::PWM_W-1:0]       pwm_hist_reg  [NCH][tapm_pkg::PWM_WINDOW];
    logic        [tapm_pkg::PWM_SUM_W-1:0]   pwm_total_reg [NCH];
    logic        [tapm_pkg::PWM_SUM_W-1:0]   pwm_total_next [NCH];
    logic        [tapm_pkg::PWM_SLOT_W-1:0]  pwm_slot_reg;
    logic        [tapm_pkg::PWM_SLOT_W-1:0]  pwm_slot_next;

    // pipeline
    logic                                    adv;
    logic                                    accept;
    logic signed [tapm_pkg::ANGLE_W-1:0]     angle_in [NCH];
    logic        [tapm_pkg::PWM_W-1:0]       fb_in    [NCH];

    logic                                    a_vld_reg;
    logic        [tapm_pkg::PWM_W-1:0]       a_fb_reg [NCH];

    logic                                    b_vld_reg;
    logic        [tapm_pkg::ANGLE_W-1:0]     b_mag_reg  [NCH];
    logic        [tapm_pkg::ANGLE_W-1:0]     b_mag_next [NCH];
    logic                                    b_neg_reg  [NCH];
    logic        [tapm_pkg::PWM_W-1:0]       b_fb_reg   [NCH];

    logic                                    c_vld_reg;
    logic signed [tapm_pkg::PROD_W-1:0]      c_prod_reg  [NCH];
    logic signed [tapm_pkg::PROD_W-1:0]      c_prod_next [NCH];
    logic                                    c_in_range_reg  [NCH];
    logic                                    c_in_range_next [NCH];
    logic        [tapm_pkg::PWM_W-1:0]       c_fb_reg    [NCH];

    logic                                    d_vld_reg;
    logic        [tapm_pkg::PWM_W-1:0]       raw_pwm  [NCH];
    logic        [tapm_pkg::PWM_ACC_W-1:0]   d_sum_reg  [NCH];
    logic        [tapm_pkg::PWM_ACC_W-1:0]   d_sum_next [NCH];

    logic                                    m_valid_reg;
    logic        [tapm_pkg::PWM_W-1:0]       m_pwm_reg  [NCH];
    logic        [tapm_pkg::PWM_W-1:0]       m_pwm_next [NCH];

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && adv;
    assign m_valid = m_valid_reg;
    assign m_pwm_a = m_pwm_reg[0];
    assign m_pwm_b = m_pwm_reg[1];
    assign pready  = 1'b1;

    assign angle_in[0] = s_angle_a;
    assign angle_in[1] = s_angle_b;
    assign fb_in[0]    = s_fallback_pwm_a;
    assign fb_in[1]    = s_fallback_pwm_b;

    assign cfg_idx = tapm_pkg::cfg_idx_t'(paddr[tapm_pkg::CFG_ADDR_W-1:2]);

    always_comb begin
        case (cfg_idx)
            tapm_pkg::CFG_MIN_A:    prdata = tapm_pkg::CFG_DATA_W'(min_angle_reg[0]);
            tapm_pkg::CFG_MAX_A:    prdata = tapm_pkg::CFG_DATA_W'(max_angle_reg[0]);
            tapm_pkg::CFG_SLOPE_A:  prdata = tapm_pkg::CFG_DATA_W'(slope_reg[0]);
            tapm_pkg::CFG_OFFSET_A: prdata = tapm_pkg::CFG_DATA_W'(offset_reg[0]);
            tapm_pkg::CFG_MIN_B:    prdata = tapm_pkg::CFG_DATA_W'(min_angle_reg[1]);
            tapm_pkg::CFG_MAX_B:    prdata = tapm_pkg::CFG_DATA_W'(max_angle_reg[1]);
            tapm_pkg::CFG_SLOPE_B:  prdata = tapm_pkg::CFG_DATA_W'(slope_reg[1]);
            tapm_pkg::CFG_OFFSET_B: prdata = tapm_pkg::CFG_DATA_W'(offset_reg[1]);
            default:                prdata = '0;
        endcase
    end

    assign angle_slot_next = (angle_slot_reg == tapm_pkg::ANGLE_SLOT_W'(tapm_pkg::ANGLE_WINDOW - 1))
                           ? '0 : angle_slot_reg + 1'b1;
    assign pwm_slot_next   = (pwm_slot_reg == tapm_pkg::PWM_SLOT_W'(tapm_pkg::PWM_WINDOW - 1))
                           ? '0 : pwm_slot_reg + 1'b1;

    always_comb begin
        logic [tapm_pkg::ANGLE_SUM_W-1:0]                         mag;
        logic [tapm_pkg::ANGLE_SUM_W+tapm_pkg::ANGLE_RECIP_W-1:0] qprod;
        logic signed [tapm_pkg::ANGLE_W:0]                        mean_wide;
        logic signed [tapm_pkg::ANGLE_W-1:0]                      mean;
        logic signed [tapm_pkg::PROD_W-1:0]                       shifted;
        logic signed [tapm_pkg::MAP_W-1:0]                        mapped;
        logic [tapm_pkg::PWM_ACC_W+tapm_pkg::PWM_RECIP_W-1:0]     oprod;
        for (int c = 0; c < NCH; c++) begin
            // stage a: angle running sum
            angle_total_next[c] = angle_total_reg[c]
                                + tapm_pkg::ANGLE_SUM_W'(angle_in[c])
                                - tapm_pkg::ANGLE_SUM_W'(angle_hist_reg[c][angle_slot_reg]);

            // stage b: |total| / window, truncation toward zero by sign and magnitude
            mag = angle_total_reg[c][tapm_pkg::ANGLE_SUM_W-1]
                ? $unsigned(-angle_total_reg[c]) : $unsigned(angle_total_reg[c]);
            qprod = tapm_pkg::ANGLE_SUM_W'(mag) * tapm_pkg::ANGLE_RECIP;
            b_mag_next[c] = tapm_pkg::ANGLE_W'(qprod >> tapm_pkg::ANGLE_DIV_SHIFT);

            // stage c: bound check and slope multiply
            mean_wide = b_neg_reg[c] ? -$signed({1'b0, b_mag_reg[c]})
                                     : $signed({1'b0, b_mag_reg[c]});
            mean = tapm_pkg::ANGLE_W'(mean_wide);
            c_in_range_next[c] = (mean > min_angle_reg[c]) && (mean < max_angle_reg[c]);
            c_prod_next[c] = slope_reg[c] * mean;

            // stage d: offset, fallback when out of range, saturation and pwm running sum
            shifted = c_prod_reg[c] >>> tapm_pkg::SLOPE_SHIFT;
            mapped  = tapm_pkg::MAP_W'(offset_reg[c]) + tapm_pkg::MAP_W'(shifted);
            if (!c_in_range_reg[c]) begin
                raw_pwm[c] = c_fb_reg[c];
            end else if (mapped < 0) begin
                raw_pwm[c] = '0;
            end else if (mapped > $signed(tapm_pkg::MAP_W'(tapm_pkg::PWM_MAX))) begin
                raw_pwm[c] = tapm_pkg::PWM_MAX;
            end else begin
                raw_pwm[c] = mapped[tapm_pkg::PWM_W-1:0];
            end
            pwm_total_next[c] = pwm_total_reg[c]
                              - tapm_pkg::PWM_SUM_W'(pwm_hist_reg[c][pwm_slot_reg])
                              + tapm_pkg::PWM_SUM_W'(raw_pwm[c]);
            d_sum_next[c] = tapm_pkg::PWM_ACC_W'(raw_pwm[c])
                          + tapm_pkg::PWM_ACC_W'(pwm_total_next[c]);

            // stage e: divide by window + 1
            oprod = tapm_pkg::PWM_ACC_W'(d_sum_reg[c]) * tapm_pkg::PWM_RECIP;
            m_pwm_next[c] = tapm_pkg::PWM_W'(oprod >> tapm_pkg::PWM_DIV_SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_angle_reg[0] <= tapm_pkg::MIN_ANGLE_A_RST;
            max_angle_reg[0] <= tapm_pkg::MAX_ANGLE_A_RST;
            slope_reg[0]     <= tapm_pkg::SLOPE_A_RST;
            offset_reg[0]    <= tapm_pkg::OFFSET_A_RST;
            min_angle_reg[1] <= tapm_pkg::MIN_ANGLE_B_RST;
            max_angle_reg[1] <= tapm_pkg::MAX_ANGLE_B_RST;
            slope_reg[1]     <= tapm_pkg::SLOPE_B_RST;
            offset_reg[1]    <= tapm_pkg::OFFSET_B_RST;
            for (int c = 0; c < NCH; c++) begin
                angle_total_reg[c] <= '0;
                pwm_total_reg[c]   <= '0;
                for (int i = 0; i < tapm_pkg::ANGLE_WINDOW; i++) begin
                    angle_hist_reg[c][i] <= '0;
                end
                for (int i = 0; i < tapm_pkg::PWM_WINDOW; i++) begin
                    pwm_hist_reg[c][i] <= '0;
                end
            end
            angle_slot_reg <= '0;
            pwm_slot_reg   <= '0;
            a_vld_reg      <= 1'b0;
            b_vld_reg      <= 1'b0;
            c_vld_reg      <= 1'b0;
            d_vld_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                case (cfg_idx)
                    tapm_pkg::CFG_MIN_A:    min_angle_reg[0] <= pwdata[tapm_pkg::ANGLE_W-1:0];
                    tapm_pkg::CFG_MAX_A:    max_angle_reg[0] <= pwdata[tapm_pkg::ANGLE_W-1:0];
                    tapm_pkg::CFG_SLOPE_A:  slope_reg[0]     <= pwdata[tapm_pkg::SLOPE_W-1:0];
                    tapm_pkg::CFG_OFFSET_A: offset_reg[0]    <= pwdata[tapm_pkg::OFFSET_W-1:0];
                    tapm_pkg::CFG_MIN_B:    min_angle_reg[1] <= pwdata[tapm_pkg::ANGLE_W-1:0];
                    tapm_pkg::CFG_MAX_B:    max_angle_reg[1] <= pwdata[tapm_pkg::ANGLE_W-1:0];
                    tapm_pkg::CFG_SLOPE_B:  slope_reg[1]     <= pwdata[tapm_pkg::SLOPE_W-1:0];
                    tapm_pkg::CFG_OFFSET_B: offset_reg[1]    <= pwdata[tapm_pkg::OFFSET_W-1:0];
                    default: ;
                endcase
            end
            if (adv) begin
                a_vld_reg   <= s_valid;
                b_vld_reg   <= a_vld_reg;
                c_vld_reg   <= b_vld_reg;
                d_vld_reg   <= c_vld_reg;
                m_valid_reg <= d_vld_reg;
            end
            if (accept) begin
                for (int c = 0; c < NCH; c++) begin
                    angle_total_reg[c] <= angle_total_next[c];
                    angle_hist_reg[c][angle_slot_reg] <= angle_in[c];
                end
                angle_slot_reg <= angle_slot_next;
            end
            if (adv && c_vld_reg) begin
                for (int c = 0; c < NCH; c++) begin
                    pwm_total_reg[c] <= pwm_total_next[c];
                    pwm_hist_reg[c][pwm_slot_reg] <= raw_pwm[c];
                end
                pwm_slot_reg <= pwm_slot_next;
            end
        end
    end

    // payload stages; stage a's total is angle_total_reg itself, which holds
    // until the next request, and no request can enter while the pipe stalls
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < NCH; c++) begin
                a_fb_reg[c]       <= fb_in[c];
                b_mag_reg[c]      <= b_mag_next[c];
                b_neg_reg[c]      <= angle_total_reg[c][tapm_pkg::ANGLE_SUM_W-1];
                b_fb_reg[c]       <= a_fb_reg[c];
                c_prod_reg[c]     <= c_prod_next[c];
                c_in_range_reg[c] <= c_in_range_next[c];
                c_fb_reg[c]       <= b_fb_reg[c];
                d_sum_reg[c]      <= d_sum_next[c];
                m_pwm_reg[c]      <= m_pwm_next[c];
            end
        end
    end

endmodule
